// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the ellipse arc interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define EAI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define EAI_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `EAI_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ----- rtl/core/eai_pkg.sv -----
// Shared types, constants and tables of the ellipse arc interpolator.
package eai_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int CNT_W             = $clog2(CORDIC_ITERATIONS);

    // Field widths
    localparam int COORD_W  = 32;
    localparam int ANGLE_W  = 32;
    localparam int RATIO_W  = 17;
    localparam int SEGLEN_W = 25;
    localparam int MINSEG_W = 13;
    localparam int CFG_W    = 25;
    localparam int CFG_IDX_W = 2;

    // Datapath widths
    localparam int CW     = 36;
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int ACC_W  = MUL_PW + 1;
    localparam int DIV_W  = 36;
    localparam int DCNT_W = $clog2(DIV_W);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEGMENTS   = 2'd1;

    localparam logic [SEGLEN_W-1:0] SEGLEN_RESET = 25'd65536;
    localparam logic [MINSEG_W-1:0] MINSEG_RESET = 13'd16;
    localparam logic [RATIO_W-1:0]  RATIO_ONE    = 17'd65536;

    // Opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Angle constants: Q4.28 and Q2.30
    localparam logic [30:0]          TWO_PI_Q28  = 31'd1686629713;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = CW'(64'd6746518852);
    localparam logic signed [CW-1:0] PI_Q30      = CW'(64'd3373259426);
    localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'd1686629713);
    localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'd652032874);
    localparam logic signed [MUL_BW-1:0] GAIN_B  = MUL_BW'(64'd652032874);

    typedef struct packed {
        logic start;
        logic vec_mode;
    } t_cordic_req;

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            5'd20: v = 32'd1024;
            5'd21: v = 32'd512;
            5'd22: v = 32'd256;
            5'd23: v = 32'd128;
            5'd24: v = 32'd64;
            5'd25: v = 32'd32;
            5'd26: v = 32'd16;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return CW'(v);
    endfunction

endpackage

// ----- rtl/core/eai_in_if.sv -----
// Input channel of the ellipse arc interpolator: one command word.
interface eai_in_if import eai_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic signed [COORD_W-1:0]  centre_x;
    logic signed [COORD_W-1:0]  centre_y;
    logic signed [COORD_W-1:0]  axis_x;
    logic signed [COORD_W-1:0]  axis_y;
    logic        [RATIO_W-1:0]  axis_ratio;
    logic signed [ANGLE_W-1:0]  start_angle;
    logic signed [ANGLE_W-1:0]  end_angle;

    modport source (output valid, opcode, centre_x, centre_y, axis_x, axis_y,
                    axis_ratio, start_angle, end_angle, input ready);
    modport sink   (input valid, opcode, centre_x, centre_y, axis_x, axis_y,
                    axis_ratio, start_angle, end_angle, output ready);
endinterface

// ----- rtl/core/eai_out_if.sv -----
// Output channel of the ellipse arc interpolator: one point word.
interface eai_out_if import eai_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic                       pen_down;
    logic                       last;
    logic                       status;

    modport source (output valid, point_x, point_y, pen_down, last, status,
                    input ready);
    modport sink   (input valid, point_x, point_y, pen_down, last, status,
                    output ready);
endinterface

// ----- rtl/core/eai_mul.sv -----
// Shared signed multiplier with a registered product.
module eai_mul import eai_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_AW-1:0]  i_a,
    input  logic signed [MUL_BW-1:0]  i_b,
    output logic signed [MUL_PW-1:0]  o_p
);
    logic signed [MUL_PW-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// ----- rtl/core/eai_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
module eai_div import eai_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quo,
    output logic [DIV_W-1:0]  o_rem
);
    typedef enum logic {D_IDLE, D_RUN} t_dstate;

    t_dstate            r_state;
    logic [DCNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [DIV_W-1:0]   r_div;
    logic               r_done;
    logic [DIV_W:0]     trial;
    logic               fits;

    // Trial subtract of the shifted remainder
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_rem   <= '0;
                        r_quo   <= i_dividend;
                        r_div   <= i_divisor;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= fits ? DIV_W'(trial - {1'b0, r_div}) : trial[DIV_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ----- rtl/core/eai_cordic.sv -----
// Shared CORDIC unit: rotation gives cosine and sine, vectoring gives length and angle.
module eai_cordic import eai_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cordic_req           i_req,
    input  logic signed [CW-1:0]  i_x,
    input  logic signed [CW-1:0]  i_y,
    input  logic signed [CW-1:0]  i_z,
    output logic                  o_done,
    output logic signed [CW-1:0]  o_x,
    output logic signed [CW-1:0]  o_y,
    output logic signed [CW-1:0]  o_z
);
    typedef enum logic [2:0] {C_IDLE, C_RED0, C_RED1, C_RED2, C_RED3, C_RUN} t_cstate;

    t_cstate               r_state;
    logic                  r_vec;
    logic                  r_neg;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [CW-1:0]  r_x;
    logic signed [CW-1:0]  r_y;
    logic signed [CW-1:0]  r_z;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic signed [CW-1:0]  at;
    logic                  up;

    // Micro-rotation terms
    assign dx = r_y >>> r_cnt;
    assign dy = r_x >>> r_cnt;
    assign at = atan_q30(5'(r_cnt));
    assign up = r_vec ? (r_y >= 0) : (r_z < 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_vec <= i_req.vec_mode;
                        r_neg <= 1'b0;
                        r_cnt <= '0;
                        if (i_req.vec_mode) begin
                            // fold the left half plane onto the right
                            if (i_x < 0) begin
                                r_x <= -i_x;
                                r_y <= -i_y;
                                r_z <= (i_y >= 0) ? PI_Q30 : -PI_Q30;
                            end else begin
                                r_x <= i_x;
                                r_y <= i_y;
                                r_z <= '0;
                            end
                            r_state <= C_RUN;
                        end else begin
                            r_x     <= i_x;
                            r_y     <= i_y;
                            r_z     <= i_z;
                            r_state <= C_RED0;
                        end
                    end
                end
                // reduce the angle to one turn, then to the right half plane
                C_RED0: begin
                    if (r_z >= TWO_PI_Q30) begin
                        r_z <= r_z - TWO_PI_Q30;
                    end else if (r_z <= -TWO_PI_Q30) begin
                        r_z <= r_z + TWO_PI_Q30;
                    end
                    r_state <= C_RED1;
                end
                C_RED1: begin
                    if (r_z < 0) begin
                        r_z <= r_z + TWO_PI_Q30;
                    end
                    r_state <= C_RED2;
                end
                C_RED2: begin
                    if (r_z > PI_Q30) begin
                        r_z <= r_z - TWO_PI_Q30;
                    end
                    r_state <= C_RED3;
                end
                C_RED3: begin
                    if (r_z > HALF_PI_Q30) begin
                        r_z   <= r_z - PI_Q30;
                        r_neg <= 1'b1;
                    end else if (r_z < -HALF_PI_Q30) begin
                        r_z   <= r_z + PI_Q30;
                        r_neg <= 1'b1;
                    end
                    r_state <= C_RUN;
                end
                C_RUN: begin
                    if (up) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CORDIC_ITERATIONS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_x    = r_neg ? -r_x : r_x;
    assign o_y    = r_neg ? -r_y : r_y;
    assign o_z    = r_z;
endmodule

// ----- rtl/core/ellipse_arc_interpolator_unit.sv -----
// Ellipse arc interpolator top level: sequencer around a shared CORDIC, multiplier and divider.
// Advance: CORDIC rotation at the new angle, point arithmetic, then the output register.
// Load: three CORDIC passes and two divides, then the first point goes out like an advance.
// Idle advance: a status word only. Input is ready once the word enters the output register.
// One word at a time; the next word is taken while a finished point waits at the output.
// Reset is synchronous, active low: no shape loaded, registers at their defaults, no clearing pass.
`include "assert_macros.svh"

module ellipse_arc_interpolator_unit import eai_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    eai_in_if.sink                i_in,
    eai_out_if.source             o_out
);
    typedef enum logic [4:0] {
        S_IDLE, S_VEC, S_MAG, S_MAGR, S_MIN, S_MINR, S_ROT, S_NUM, S_NUMR,
        S_DIV1, S_DIV2, S_SC, S_E_LX, S_E_LY, S_E_A, S_E_B, S_E_C, S_E_D,
        S_E_E, S_E_F, S_OUT
    } t_state;

    localparam logic signed [MUL_PW-1:0] RND30 = MUL_PW'(64'd1 << 29);
    localparam logic signed [MUL_PW-1:0] RND16 = MUL_PW'(64'd1 << 15);
    localparam logic signed [ACC_W-1:0]  RNDA  = ACC_W'(64'd1 << 29);
    localparam logic signed [MUL_PW-1:0] U32_MAX = MUL_PW'(64'hFFFF_FFFF);

    t_state                     r_state;
    logic [SEGLEN_W-1:0]        r_seglen;
    logic [MINSEG_W-1:0]        r_minseg;

    // Shape state
    logic signed [COORD_W-1:0]  r_cx;
    logic signed [COORD_W-1:0]  r_cy;
    logic [31:0]                r_major;
    logic [31:0]                r_minor;
    logic signed [31:0]         r_rc;
    logic signed [31:0]         r_rs;
    logic signed [ANGLE_W-1:0]  r_cur;
    logic signed [ANGLE_W-1:0]  r_fin;
    logic [31:0]                r_step;
    logic                       r_active;

    // Working registers
    logic [RATIO_W-1:0]         r_ratio;
    logic signed [MUL_AW-1:0]   r_xf;
    logic signed [CW-1:0]       r_z;
    logic                       r_frac;
    logic signed [ANGLE_W-1:0]  r_ang;
    logic signed [31:0]         r_c;
    logic signed [31:0]         r_s;
    logic signed [MUL_AW-1:0]   r_lx;
    logic signed [MUL_AW-1:0]   r_ly;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [COORD_W-1:0]  r_px;
    logic signed [COORD_W-1:0]  r_py;
    logic                       r_pen;
    logic                       r_last;
    logic                       r_status;

    // Output register
    logic                       r_ov;
    logic signed [COORD_W-1:0]  r_ox;
    logic signed [COORD_W-1:0]  r_oy;
    logic                       r_open;
    logic                       r_olast;
    logic                       r_ostat;

    // Shared unit connections
    t_cordic_req                c_req;
    logic signed [CW-1:0]       c_x;
    logic signed [CW-1:0]       c_y;
    logic signed [CW-1:0]       c_z;
    logic                       c_done;
    logic signed [CW-1:0]       c_xo;
    logic signed [CW-1:0]       c_yo;
    logic signed [CW-1:0]       c_zo;
    logic signed [MUL_AW-1:0]   mul_a;
    logic signed [MUL_BW-1:0]   mul_b;
    logic signed [MUL_PW-1:0]   mul_p;
    logic                       div_start;
    logic [DIV_W-1:0]           div_n;
    logic [DIV_W-1:0]           div_d;
    logic                       d_done;
    logic [DIV_W-1:0]           d_quo;
    logic [DIV_W-1:0]           d_rem;

    // Datapath terms
    logic                       in_acc;
    logic signed [MUL_PW-1:0]   p30;
    logic signed [MUL_PW-1:0]   p16;
    logic signed [ACC_W-1:0]    p_ext;
    logic signed [ACC_W-1:0]    acc30;
    logic signed [37:0]         sum_x;
    logic signed [37:0]         sum_y;
    logic signed [ANGLE_W:0]    next_ang;
    logic                       arc_end;
    logic signed [ANGLE_W-1:0]  adv_ang;
    logic signed [ANGLE_W:0]    end_wrap;
    logic [DIV_W-1:0]           seg36;
    logic [DIV_W-1:0]           minseg36;
    logic [DIV_W-1:0]           steps_raw;
    logic [DIV_W-1:0]           steps_max;
    logic                       stat_word;
    logic                       stat_clear;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q4.28 angle to Q2.30
    function automatic logic signed [CW-1:0] ang_to_z(input logic signed [ANGLE_W-1:0] a);
        return {{(CW - ANGLE_W - 2){a[ANGLE_W-1]}}, a, 2'b00};
    endfunction

    eai_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_req),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_z     (c_z),
        .o_done  (c_done),
        .o_x     (c_xo),
        .o_y     (c_yo),
        .o_z     (c_zo)
    );

    eai_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    eai_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (d_done),
        .o_quo      (d_quo),
        .o_rem      (d_rem)
    );

    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Rounded product slices and accumulator terms
    assign p30   = (mul_p + RND30) >>> 30;
    assign p16   = (mul_p + RND16) >>> 16;
    assign p_ext = ACC_W'(mul_p);
    assign acc30 = r_acc >>> 30;
    assign sum_x = 38'(r_cx) + acc30[37:0];
    assign sum_y = 38'(r_cy) + acc30[37:0];

    // Next point angle of an advance
    assign next_ang = (ANGLE_W + 1)'(r_cur) + {1'b0, r_step};
    assign arc_end  = !(next_ang < (ANGLE_W + 1)'(r_fin));
    assign adv_ang  = arc_end ? r_fin : next_ang[ANGLE_W-1:0];
    assign end_wrap = (ANGLE_W + 1)'(i_in.end_angle) + (ANGLE_W + 1)'(TWO_PI_Q28);

    // Segment count terms
    assign seg36     = DIV_W'((r_seglen == '0) ? SEGLEN_W'(1) : r_seglen);
    assign minseg36  = DIV_W'((r_minseg == '0) ? MINSEG_W'(1) : r_minseg);
    assign steps_raw = d_quo + DIV_W'((d_rem != '0) || r_frac);
    assign steps_max = (steps_raw < minseg36) ? minseg36 : steps_raw;

    // Drive the shared units
    always_comb begin
        c_req     = '0;
        c_x       = GAIN_Q30;
        c_y       = '0;
        c_z       = ang_to_z(r_ang);
        div_start = 1'b0;
        div_n     = mul_p[63:28];
        div_d     = seg36;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.opcode == OP_LOAD)) begin
                    c_req = '{start: 1'b1, vec_mode: 1'b1};
                    c_x   = CW'(i_in.axis_x);
                    c_y   = CW'(i_in.axis_y);
                end else if (in_acc && r_active) begin
                    c_req = '{start: 1'b1, vec_mode: 1'b0};
                    c_z   = ang_to_z(adv_ang);
                end
            end
            S_MAG: begin
                mul_a = r_xf;
                mul_b = GAIN_B;
            end
            S_MIN: begin
                mul_a = MUL_AW'(r_major);
                mul_b = MUL_BW'(r_ratio);
            end
            S_MINR: begin
                c_req = '{start: 1'b1, vec_mode: 1'b0};
                c_z   = r_z;
            end
            S_NUM: begin
                mul_a = MUL_AW'(r_major);
                mul_b = MUL_BW'(TWO_PI_Q28);
            end
            S_NUMR: begin
                div_start = 1'b1;
            end
            S_DIV1: begin
                if (d_done) begin
                    div_start = 1'b1;
                    div_n     = DIV_W'(TWO_PI_Q28);
                    div_d     = steps_max;
                end
            end
            S_DIV2: begin
                if (d_done) begin
                    c_req = '{start: 1'b1, vec_mode: 1'b0};
                    c_z   = ang_to_z(r_cur);
                end
            end
            S_E_LX: begin
                mul_a = MUL_AW'(r_major);
                mul_b = r_c;
            end
            S_E_LY: begin
                mul_a = MUL_AW'(r_minor);
                mul_b = r_s;
            end
            S_E_A: begin
                mul_a = r_lx;
                mul_b = r_rc;
            end
            S_E_B: begin
                mul_a = r_ly;
                mul_b = r_rs;
            end
            S_E_C: begin
                mul_a = r_ly;
                mul_b = r_rc;
            end
            S_E_D: begin
                mul_a = r_lx;
                mul_b = r_rs;
            end
            default: ;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seglen <= SEGLEN_RESET;
            r_minseg <= MINSEG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEGMENT_LENGTH: r_seglen <= i_cfg_data[SEGLEN_W-1:0];
                CFG_MIN_SEGMENTS:   r_minseg <= i_cfg_data[MINSEG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_ov     <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_major  <= '0;
            r_minor  <= '0;
            r_rc     <= '0;
            r_rs     <= '0;
            r_cur    <= '0;
            r_fin    <= '0;
            r_step   <= '0;
        end else begin
            // drop the output word once taken, unless a new one is loaded below
            if (o_out.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.opcode == OP_LOAD) begin
                            r_cx    <= i_in.centre_x;
                            r_cy    <= i_in.centre_y;
                            r_ratio <= (i_in.axis_ratio > RATIO_ONE) ? RATIO_ONE
                                                                     : i_in.axis_ratio;
                            // a reversed sweep wraps the end, or the start if the end overflows
                            if (i_in.end_angle < i_in.start_angle) begin
                                if (end_wrap > (ANGLE_W + 1)'(33'sd2147483647)) begin
                                    r_cur <= ANGLE_W'((ANGLE_W + 1)'(i_in.start_angle)
                                                      - (ANGLE_W + 1)'(TWO_PI_Q28));
                                    r_fin <= i_in.end_angle;
                                end else begin
                                    r_cur <= i_in.start_angle;
                                    r_fin <= end_wrap[ANGLE_W-1:0];
                                end
                            end else begin
                                r_cur <= i_in.start_angle;
                                r_fin <= i_in.end_angle;
                            end
                            r_state <= S_VEC;
                        end else if (!r_active) begin
                            r_px     <= '0;
                            r_py     <= '0;
                            r_pen    <= 1'b0;
                            r_last   <= 1'b0;
                            r_status <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_cur    <= adv_ang;
                            r_ang    <= adv_ang;
                            r_pen    <= 1'b1;
                            r_last   <= arc_end;
                            r_status <= 1'b0;
                            if (arc_end) begin
                                r_active <= 1'b0;
                            end
                            r_state  <= S_SC;
                        end
                    end
                end
                S_VEC: begin
                    if (c_done) begin
                        r_xf    <= c_xo[MUL_AW-1:0];
                        r_z     <= c_zo;
                        r_state <= S_MAG;
                    end
                end
                S_MAG:  r_state <= S_MAGR;
                S_MAGR: begin
                    r_major <= (p30 > U32_MAX) ? 32'hFFFF_FFFF : p30[31:0];
                    r_state <= S_MIN;
                end
                S_MIN:  r_state <= S_MINR;
                S_MINR: begin
                    r_minor <= p16[31:0];
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (c_done) begin
                        r_rc    <= sat32(38'(c_xo));
                        r_rs    <= sat32(38'(c_yo));
                        r_state <= S_NUM;
                    end
                end
                S_NUM:  r_state <= S_NUMR;
                S_NUMR: begin
                    r_frac  <= (mul_p[27:0] != '0);
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (d_done) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (d_done) begin
                        r_step   <= (d_quo == '0) ? 32'd1 : d_quo[31:0];
                        r_active <= 1'b1;
                        r_ang    <= r_cur;
                        r_pen    <= 1'b0;
                        r_last   <= 1'b0;
                        r_status <= 1'b0;
                        r_state  <= S_SC;
                    end
                end
                S_SC: begin
                    if (c_done) begin
                        r_c     <= c_xo[31:0];
                        r_s     <= c_yo[31:0];
                        r_state <= S_E_LX;
                    end
                end
                S_E_LX: r_state <= S_E_LY;
                S_E_LY: begin
                    r_lx    <= p30[MUL_AW-1:0];
                    r_state <= S_E_A;
                end
                S_E_A: begin
                    r_ly    <= p30[MUL_AW-1:0];
                    r_state <= S_E_B;
                end
                S_E_B: begin
                    r_acc   <= p_ext;
                    r_state <= S_E_C;
                end
                // x: lx*cos - ly*sin, rounded
                S_E_C: begin
                    r_acc   <= r_acc - p_ext + RNDA;
                    r_state <= S_E_D;
                end
                S_E_D: begin
                    r_px    <= sat32(sum_x);
                    r_acc   <= p_ext;
                    r_state <= S_E_E;
                end
                // y: ly*cos + lx*sin, rounded
                S_E_E: begin
                    r_acc   <= r_acc + p_ext + RNDA;
                    r_state <= S_E_F;
                end
                S_E_F: begin
                    r_py    <= sat32(sum_y);
                    r_state <= S_OUT;
                end
                // hand the point to the output register once it is free
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_px;
                        r_oy    <= r_py;
                        r_open  <= r_pen;
                        r_olast <= r_last;
                        r_ostat <= r_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.point_x  = r_ox;
    assign o_out.point_y  = r_oy;
    assign o_out.pen_down = r_open;
    assign o_out.last     = r_olast;
    assign o_out.status   = r_ostat;

    assign stat_word  = o_out.valid && o_out.status;
    assign stat_clear = !o_out.pen_down && !o_out.last && (o_out.point_x == '0)
                        && (o_out.point_y == '0);

    `EAI_ASSERT_NEVER(a_div_zero, i_clk, i_rst_n, div_start && (div_d == '0), "zero divisor")
    `EAI_ASSERT(a_step_nonzero, i_clk, i_rst_n, r_active |-> (r_step != '0), "zero angle step")
    `EAI_ASSERT(a_status_word, i_clk, i_rst_n, stat_word |-> stat_clear, "status word with point")
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the ellipse arc interpolator unit.
`timescale 1ns / 100ps

module tb_top;
    import eai_pkg::*;

    localparam int              WATCHDOG_LIMIT = 5000;
    localparam int              DRAIN_CYCLES   = 250;
    localparam int              HOLD_CYCLES    = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint K_TWO_PI_Q28  = 64'd1686629713;
    localparam longint K_PI_Q30      = 64'd3373259426;
    localparam longint K_TWO_PI_Q30  = 64'd6746518852;
    localparam longint K_HALF_PI_Q30 = 64'd1686629713;
    localparam longint K_GAIN_Q30    = 64'd652032874;
    localparam longint K_S32_MAX     = 64'sd2147483647;
    localparam longint K_S32_MIN     = -64'sd2147483648;

    typedef struct {
        logic                      op;
        logic signed [COORD_W-1:0] cx, cy, ax, ay;
        logic [RATIO_W-1:0]        ratio;
        logic signed [ANGLE_W-1:0] sa, ea;
    } arc_cmd_t;

    typedef struct {
        logic signed [COORD_W-1:0] px, py;
        logic                      pen, last, status;
    } arc_point_t;

    typedef struct {
        arc_cmd_t   cmd;
        bit         typed;
        arc_point_t pt;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    eai_in_if  in_if();
    eai_out_if out_if();

    ellipse_arc_interpolator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shape state of the point predictor
    longint unsigned seg_len_q, min_seg_q;
    longint org_x, org_y, rad_major, rad_minor, rot_c, rot_s;
    longint cur_ang, fin_ang, step_ang;
    bit     shape_on;
    longint arctan_tab[32];

    arc_point_t point_q[$];
    bit         typed_q[$];
    arc_point_t typed_pt_q[$];
    int         err_cnt = 0;
    bit         no_idle = 1'b0;
    bit         hold_go = 1'b0;
    int         hold_left = 0;
    int         quiet_cnt = 0;

    function automatic longint rnd_shr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > K_S32_MAX) return K_S32_MAX;
        if (v < K_S32_MIN) return K_S32_MIN;
        return v;
    endfunction

    // Rotation-mode CORDIC: cosine and sine of a Q2.30 angle
    function automatic void cos_sin(input longint a, output longint c, output longint s);
        longint r, x, y, z, dx, dy;
        bit neg;
        r = a % K_TWO_PI_Q30;
        x = K_GAIN_Q30;
        y = 0;
        neg = 1'b0;
        if (r < 0) r += K_TWO_PI_Q30;
        if (r > K_PI_Q30) r -= K_TWO_PI_Q30;
        if (r > K_HALF_PI_Q30) begin
            r -= K_PI_Q30;
            neg = 1'b1;
        end else if (r < -K_HALF_PI_Q30) begin
            r += K_PI_Q30;
            neg = 1'b1;
        end
        z = r;
        for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_tab[i];
            end else begin
                x += dx; y -= dy; z += arctan_tab[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    // Vectoring-mode CORDIC: length and direction of the major axis
    function automatic void axis_polar(input longint x, input longint y,
                                       output longint mag, output longint ang);
        longint z, dx, dy;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? K_PI_Q30 : -K_PI_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_tab[i];
            end else begin
                x -= dx; y += dy; z -= arctan_tab[i];
            end
        end
        mag = rnd_shr(x * K_GAIN_Q30, 30);
        ang = z;
    endfunction

    function automatic arc_point_t arc_point_at(longint ang, logic pen, logic lst);
        longint c, s, lx, ly;
        arc_point_t p;
        cos_sin(ang * 4, c, s);
        lx = rnd_shr(rad_major * c, 30);
        ly = rnd_shr(rad_minor * s, 30);
        p.px = 32'(clamp32(org_x + rnd_shr(lx * rot_c - ly * rot_s, 30)));
        p.py = 32'(clamp32(org_y + rnd_shr(ly * rot_c + lx * rot_s, 30)));
        p.pen = pen;
        p.last = lst;
        p.status = 1'b0;
        return p;
    endfunction

    // Advance the shape state by one command word and give its point
    function automatic arc_point_t next_point(arc_cmd_t cmd);
        longint mag, ang, c, s, st, en, fin, nxt;
        longint unsigned ratio, seg, mseg, num, den, steps, stp;
        arc_point_t p;
        if (cmd.op == OP_LOAD) begin
            ratio = cmd.ratio;
            if (ratio > 65536) ratio = 65536;
            org_x = cmd.cx;
            org_y = cmd.cy;
            axis_polar(longint'(cmd.ax), longint'(cmd.ay), mag, ang);
            if (mag > 64'd4294967295) mag = 64'd4294967295;
            rad_major = mag;
            rad_minor = rnd_shr(mag * longint'(ratio), 16);
            cos_sin(ang, c, s);
            rot_c = clamp32(c);
            rot_s = clamp32(s);
            seg = seg_len_q ? seg_len_q : 1;
            mseg = min_seg_q ? min_seg_q : 1;
            num = longint'(rad_major) * K_TWO_PI_Q28;
            den = seg << 28;
            steps = num / den + ((num % den) != 0 ? 1 : 0);
            if (steps < mseg) steps = mseg;
            stp = K_TWO_PI_Q28 / steps;
            if (stp == 0) stp = 1;
            step_ang = longint'(stp);
            st = cmd.sa;
            en = cmd.ea;
            fin = en;
            if (en < st) begin
                fin = en + K_TWO_PI_Q28;
                if (fin > K_S32_MAX) begin
                    st -= K_TWO_PI_Q28;
                    fin = en;
                end
            end
            cur_ang = st;
            fin_ang = fin;
            shape_on = 1'b1;
            return arc_point_at(cur_ang, 1'b0, 1'b0);
        end
        if (!shape_on) begin
            p = '{px: 0, py: 0, pen: 1'b0, last: 1'b0, status: 1'b1};
            return p;
        end
        nxt = cur_ang + step_ang;
        if (nxt < fin_ang) begin
            cur_ang = nxt;
            return arc_point_at(cur_ang, 1'b1, 1'b0);
        end
        cur_ang = fin_ang;
        shape_on = 1'b0;
        return arc_point_at(fin_ang, 1'b1, 1'b1);
    endfunction

    // Predict accepted words, check delivered points
    always @(posedge i_clk) begin
        arc_point_t e, pred;
        bit t;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (point_q.size() == 0) begin
                $error("unexpected point word x=%0d y=%0d", out_if.point_x, out_if.point_y);
                err_cnt++;
            end else begin
                e = point_q.pop_front();
                if (out_if.point_x !== e.px) begin
                    $error("point_x exp %0d got %0d", e.px, out_if.point_x); err_cnt++;
                end
                if (out_if.point_y !== e.py) begin
                    $error("point_y exp %0d got %0d", e.py, out_if.point_y); err_cnt++;
                end
                if (out_if.pen_down !== e.pen) begin
                    $error("pen_down exp %0d got %0d", e.pen, out_if.pen_down); err_cnt++;
                end
                if (out_if.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, out_if.last); err_cnt++;
                end
                if (out_if.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, out_if.status); err_cnt++;
                end
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            pred = next_point('{op: in_if.opcode, cx: in_if.centre_x, cy: in_if.centre_y,
                                ax: in_if.axis_x, ay: in_if.axis_y,
                                ratio: in_if.axis_ratio, sa: in_if.start_angle,
                                ea: in_if.end_angle});
            t = typed_q.pop_front();
            e = typed_pt_q.pop_front();
            point_q.insert(point_q.size(), t ? e : pred);
        end
    end

    // Output side: random back-pressure and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= no_idle || ($urandom % 100) >= 28;
            end
        end
    end

    // Watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || i_cfg_we) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    task automatic send_word(arc_cmd_t cmd, bit typed = 1'b0, arc_point_t pt = '{default: 0});
        while (!no_idle && ($urandom % 100) < 28) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_q.insert(typed_q.size(), typed);
        typed_pt_q.insert(typed_pt_q.size(), pt);
        in_if.valid       <= 1'b1;
        in_if.opcode      <= cmd.op;
        in_if.centre_x    <= cmd.cx;
        in_if.centre_y    <= cmd.cy;
        in_if.axis_x      <= cmd.ax;
        in_if.axis_y      <= cmd.ay;
        in_if.axis_ratio  <= cmd.ratio;
        in_if.start_angle <= cmd.sa;
        in_if.end_angle   <= cmd.ea;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic drain_points();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_SEGMENT_LENGTH) seg_len_q = val;
        else if (idx == CFG_MIN_SEGMENTS) min_seg_q = val[MINSEG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic arc_cmd_t mk_load(int cx, int cy, int ax, int ay, int ratio,
                                         int sa, int ea);
        arc_cmd_t c;
        c = '{op: OP_LOAD, cx: cx, cy: cy, ax: ax, ay: ay, ratio: ratio[RATIO_W-1:0],
              sa: sa, ea: ea};
        return c;
    endfunction

    function automatic arc_cmd_t mk_adv();
        arc_cmd_t c;
        c = '{op: OP_ADVANCE, cx: $urandom, cy: $urandom, ax: $urandom, ay: $urandom,
              ratio: $urandom, sa: $urandom, ea: $urandom};
        return c;
    endfunction

    function automatic int rnd_axis();
        case ($urandom % 4)
            0: return 0;
            1: return $urandom;
            default: return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    // One random shape: a load followed by a run of advances, or now and then a lone advance
    task automatic rand_shape(ref int left);
        arc_cmd_t c;
        int sa, n;
        if (($urandom % 10) == 0) begin
            send_word(mk_adv());
            left--;
            return;
        end
        sa = $urandom;
        c = mk_load($urandom, $urandom, rnd_axis(), rnd_axis(),
                    ($urandom % 5 == 0) ? $urandom : $urandom_range(0, 65536), sa,
                    ($urandom % 2) ? sa + int'($urandom_range(0, 32'h1000_0000))
                                   : int'($urandom));
        send_word(c);
        left--;
        n = $urandom_range(0, 14);
        for (int i = 0; i < n && left > 0; i++) begin
            send_word(mk_adv());
            left--;
        end
    endtask

    initial begin
        dir_row_t rows[$];
        arc_point_t idle_pt;
        int left;
        int unsigned seg_set[5];
        int unsigned mseg_set[5];

        arctan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                       16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                       131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                       128, 64, 32, 16, 8, 4, 2, 1, 0};
        seg_len_q = 65536;
        min_seg_q = 16;
        shape_on = 1'b0;
        org_x = 0; org_y = 0; rad_major = 0; rad_minor = 0; rot_c = 0; rot_s = 0;
        cur_ang = 0; fin_ang = 0; step_ang = 0;

        // Hold reset, configuration and the input channel at a known level from time zero
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.opcode = OP_LOAD;
        in_if.centre_x = '0; in_if.centre_y = '0;
        in_if.axis_x = '0; in_if.axis_y = '0;
        in_if.axis_ratio = '0;
        in_if.start_angle = '0; in_if.end_angle = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at reset defaults
        idle_pt = '{px: 0, py: 0, pen: 1'b0, last: 1'b0, status: 1'b1};
        rows.insert(rows.size(), '{mk_adv(), 1'b1, idle_pt});
        rows.insert(rows.size(),
                    '{mk_load(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 65536, 0, 32'h1000_0000),
                      1'b1, '{px: 32'h7FFF_FFFF, py: 32'h8000_0000, pen: 1'b0,
                              last: 1'b0, status: 1'b0}});
        rows.insert(rows.size(), '{mk_adv(), 1'b0, idle_pt});
        rows.insert(rows.size(), '{mk_adv(), 1'b0, idle_pt});
        rows.insert(rows.size(),
                    '{mk_load(0, 0, 655360, 0, 32768, 0, 32'h0400_0000), 1'b0, idle_pt});
        repeat (4) rows.insert(rows.size(), '{mk_adv(), 1'b0, idle_pt});
        rows.insert(rows.size(), '{mk_load(-1000, 2000, 32'h8000_0000, 32'h8000_0000, 131071,
                                           32'h7FFF_FFFF, 2000000000), 1'b0, idle_pt});
        rows.insert(rows.size(), '{mk_adv(), 1'b0, idle_pt});
        rows.insert(rows.size(), '{mk_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           32'h7FFF_FFFF, 65536, 32'h8000_0000,
                                           32'h7FFF_FFFF), 1'b0, idle_pt});
        rows.insert(rows.size(), '{mk_adv(), 1'b0, idle_pt});
        rows.insert(rows.size(), '{mk_load(32'h8000_0000, 32'h8000_0000, -655360, 655360, 0,
                                           32'h1000_0000, 0), 1'b0, idle_pt});
        repeat (3) rows.insert(rows.size(), '{mk_adv(), 1'b0, idle_pt});
        rows.insert(rows.size(), '{mk_load(0, 0, 32'h0010_0000, -32'sh0010_0000, 65535,
                                           -32'sh1000_0000, 32'h0800_0000), 1'b0, idle_pt});
        repeat (3) rows.insert(rows.size(), '{mk_adv(), 1'b0, idle_pt});
        foreach (rows[i]) send_word(rows[i].cmd, rows[i].typed, rows[i].pt);

        // Random phases over several register settings
        seg_set  = '{0, 1, 25'h100_0000, 25'h1FF_FFFF, 65536};
        mseg_set = '{0, 1, 4096, 13'h1FFF, 16};
        for (int ph = 0; ph < 5; ph++) begin
            drain_points();
            write_reg(CFG_SEGMENT_LENGTH, (ph == 4) ? $urandom_range(1, 25'h1FF_FFFF)
                                                    : seg_set[ph]);
            write_reg(CFG_MIN_SEGMENTS, (ph == 4) ? $urandom_range(1, 4096) : mseg_set[ph]);
            if (ph == 2) write_reg(CFG_UNUSED, 25'h1FF_FFFF);
            no_idle = (ph == 1);
            left = 106;
            while (left > 0) begin
                rand_shape(left);
                if (ph == 2 && left < 60 && left >= 50) hold_go = 1'b1;
                if (ph == 3 && left < 55 && left >= 45) begin
                    drain_points();
                    left -= 10;
                end
            end
        end

        drain_points();
        if (point_q.size() != 0) begin
            $error("%0d expected points never arrived", point_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
